// ===== hw/rtl/lz_dictionary_hash_insert_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the phrase dictionary.
// Each macro is clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LZ_DICTIONARY_HASH_INSERT_DEFINES_SVH
`define LZ_DICTIONARY_HASH_INSERT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LZDH_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define LZDH_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LZDH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZDH_ASSERT_ALWAYS(label, expr, msg)
`define LZDH_ASSERT_IMPLIES(label, ante, cons, msg)
`define LZDH_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/lzdh_pkg.sv =====
// ---------------------------------------------------------------------------
// lzdh_pkg
// Constants and the slot layout shared by the phrase dictionary.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzdh_pkg;

    localparam int DICT_ENTRIES_DEF = 4096;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 13;
    localparam int BITS_W   = 5;
    localparam int THRESH_W = 24;
    localparam int HASH_W   = 32;

    localparam int HASH_MUL        = 177573;
    localparam int CODE_BASE       = 257;
    localparam int START_BITS      = 9;
    localparam int START_THRESHOLD = 512;

    // One slot of the hash table. A zero parent marks an empty slot.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] parent;
        logic [SYM_W-1:0]  sym;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

endpackage

`default_nettype wire

// ===== hw/rtl/lz_dictionary_hash_insert.sv =====
// ---------------------------------------------------------------------------
// lz_dictionary_hash_insert
// Phrase dictionary of an LZW-style compressor: a linear-probing hash table
// of (symbol, parent code) pairs that looks up each pair with a nonzero parent
// and inserts it on a miss, or resets the dictionary on a miss when it is full.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                   Flow
//   s_axis    in         tdata: symbol, parent_code                tvalid/tready
//   m_axis    out        tdata: next_code, code_bits;              tvalid/tready
//                        tuser: inserted, dict_reset
//
// A pair with a zero parent goes from its transfer straight to the result
// state without a table access. Any other pair passes in order through the
// transfer, the two products, their sum, the reciprocal quotient estimate,
// the remainder and its final compare-subtract, one table read per probe, and
// the result. After reset, and after every result that reports a dictionary
// reset, the block sweeps all SLOT_COUNT slots of the table clear (6144 with
// the default), one slot per cycle, with s_axis_tready low.
// A new input transfer is taken while the previous result still waits in the
// output register; a stalled m_axis only holds the block in its result state.
//
`timescale 1ns / 1ps
`default_nettype none
`include "lz_dictionary_hash_insert_defines.svh"

module lz_dictionary_hash_insert #(
    parameter int DICT_ENTRIES = lzdh_pkg::DICT_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] symbol, [20:8] parent_code, [23:21] zero
    input  logic [23:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] next_code, [17:13] code_bits, [23:18] zero
    output logic [23:0] m_axis_tdata,
    // [0] inserted, [1] dict_reset
    output logic [1:0]  m_axis_tuser
);

    import lzdh_pkg::*;

    // The table holds half again as many slots as the dictionary has entries,
    // so a probe run always ends at an empty slot.
    localparam int SLOT_COUNT  = DICT_ENTRIES + DICT_ENTRIES / 2;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int COUNT_W     = $clog2(DICT_ENTRIES + 1);
    localparam int PROD_W      = HASH_W + CODE_W;
    // The reciprocal is scaled so that it fits HASH_W bits and the quotient
    // estimate is never more than one below the true quotient.
    localparam int RECIP_SHIFT = HASH_W - 1 + SLOT_W;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / SLOT_COUNT;

    localparam logic [HASH_W-1:0]   SLOT_COUNT_H = HASH_W'(SLOT_COUNT);
    localparam logic [HASH_W-1:0]   HASH_MUL_H   = HASH_W'(HASH_MUL);
    localparam logic [HASH_W-1:0]   RECIP_H      = HASH_W'(RECIP_FULL);
    localparam logic [SLOT_W-1:0]   SLOT_LAST    = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [COUNT_W-1:0]  COUNT_FULL   = COUNT_W'(DICT_ENTRIES);
    localparam logic [BITS_W-1:0]   BITS_RESET   = BITS_W'(START_BITS);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(START_THRESHOLD);
    localparam logic [THRESH_W:0]   GROW_OFFSET  = (THRESH_W + 1)'(CODE_BASE + 1);
    localparam logic [CODE_W-1:0]   CODE_OFFSET  = CODE_W'(CODE_BASE);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_QUO,
        ST_REM,
        ST_MOD,
        ST_PROBE,
        ST_RESULT
    } state_t;

    // Control state
    state_t              state_reg,    state_next;
    logic [SLOT_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [COUNT_W-1:0]  count_reg,    count_next;
    logic [BITS_W-1:0]   width_reg,    width_next;
    logic [THRESH_W-1:0] thresh_reg,   thresh_next;
    logic                out_valid_reg, out_valid_next;

    // Working payload
    logic [SYM_W-1:0]    sym_reg,      sym_next;
    logic [CODE_W-1:0]   parent_reg,   parent_next;
    logic [HASH_W-1:0]   prod_a_reg,   prod_a_next;
    logic [HASH_W-1:0]   prod_b_reg,   prod_b_next;
    logic [HASH_W-1:0]   hash_reg,     hash_next;
    logic [HASH_W-1:0]   quo_reg,      quo_next;
    logic [SLOT_W:0]     rem_reg,      rem_next;
    logic [SLOT_W-1:0]   pos_reg,      pos_next;
    logic                res_ins_reg,  res_ins_next;
    logic                res_rst_reg,  res_rst_next;
    logic [CODE_W-1:0]   res_code_reg, res_code_next;

    // Output register payload
    logic                out_ins_reg,  out_ins_next;
    logic                out_rst_reg,  out_rst_next;
    logic [CODE_W-1:0]   out_code_reg, out_code_next;
    logic [BITS_W-1:0]   out_bits_reg, out_bits_next;

    // Datapath nets
    logic [HASH_W-1:0]   sym_ext;
    logic [HASH_W-1:0]   weight;
    logic [PROD_W-1:0]   prod_b_wide;
    logic [HASH_W-1:0]   hash_sum;
    logic [2*HASH_W-1:0] recip_wide;
    logic [HASH_W-1:0]   rem_wide;
    logic [SLOT_W:0]     csub_in;
    logic [SLOT_W-1:0]   csub_out;
    logic [THRESH_W:0]   grow_sum;
    logic [CODE_W-1:0]   sym_code;
    logic                out_load;

    // Table port nets
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    slot_t               ram_wdata;
    slot_t               slot_wr;
    logic [SLOT_BITS-1:0] ram_rdata;
    slot_t               rd_slot;

    // The symbol enters the hash as a signed byte.
    assign sym_ext     = {{(HASH_W - SYM_W){sym_reg[SYM_W-1]}}, sym_reg};
    assign weight      = SLOT_COUNT_H - sym_ext;
    assign prod_b_wide = PROD_W'(parent_reg) * PROD_W'(weight);
    assign hash_sum    = prod_a_reg + prod_b_reg;
    assign sym_code    = CODE_W'(sym_reg) + CODE_W'(1);
    assign grow_sum    = (THRESH_W + 1)'(count_reg) + GROW_OFFSET;

    // Reduction of the hash: the quotient estimate is the true quotient or one
    // below it, so the remainder it leaves is below twice SLOT_COUNT.
    assign recip_wide = (2 * HASH_W)'(hash_reg) * (2 * HASH_W)'(RECIP_H);
    assign rem_wide   = hash_reg - quo_reg * SLOT_COUNT_H;

    // The shared unit brings the remainder below SLOT_COUNT in ST_MOD, and
    // does the wrapping advance to the next slot otherwise.
    assign csub_in = (state_reg == ST_MOD) ? rem_reg
                                           : ({1'b0, pos_reg} + (SLOT_W + 1)'(1));

    lzdh_csub #(
        .WIDTH   (SLOT_W),
        .MODULUS (SLOT_COUNT)
    ) u_csub (
        .din  (csub_in),
        .dout (csub_out)
    );

    // The read address always follows the shared unit: ST_MOD gives the home
    // slot and each miss in ST_PROBE the next slot, so the slot in pos_reg and
    // its data on rd_slot are registered together.
    assign rd_slot = slot_t'(ram_rdata);

    assign slot_wr.code   = CODE_W'(count_reg) + CODE_OFFSET;
    assign slot_wr.parent = parent_reg;
    assign slot_wr.sym    = sym_reg;

    lzdh_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (csub_out),
        .rd_data (ram_rdata)
    );

    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        count_next     = count_reg;
        width_next     = width_reg;
        thresh_next    = thresh_reg;
        sym_next       = sym_reg;
        parent_next    = parent_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        hash_next      = hash_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        res_ins_next   = res_ins_reg;
        res_rst_next   = res_rst_reg;
        res_code_next  = res_code_reg;
        out_ins_next   = out_ins_reg;
        out_rst_next   = out_rst_reg;
        out_code_next  = out_code_reg;
        out_bits_next  = out_bits_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = slot_wr;
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + SLOT_W'(1);
                end
            end

            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    sym_next    = s_axis_tdata[SYM_W-1:0];
                    parent_next = s_axis_tdata[SYM_W +: CODE_W];
                    if (s_axis_tdata[SYM_W +: CODE_W] == '0)
                    begin
                        // No parent: the single-byte code, no table access.
                        res_ins_next  = 1'b0;
                        res_rst_next  = 1'b0;
                        res_code_next = CODE_W'(s_axis_tdata[SYM_W-1:0]) + CODE_W'(1);
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                prod_a_next = HASH_MUL_H * sym_ext;
                prod_b_next = prod_b_wide[HASH_W-1:0];
                state_next  = ST_ADD;
            end

            ST_ADD:
            begin
                hash_next  = hash_sum;
                state_next = ST_QUO;
            end

            ST_QUO:
            begin
                quo_next   = HASH_W'(recip_wide >> RECIP_SHIFT);
                state_next = ST_REM;
            end

            ST_REM:
            begin
                rem_next   = rem_wide[SLOT_W:0];
                state_next = ST_MOD;
            end

            ST_MOD:
            begin
                pos_next   = csub_out;
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                if (rd_slot.parent == '0)
                begin
                    res_ins_next  = 1'b1;
                    res_code_next = sym_code;
                    state_next    = ST_RESULT;
                    if (count_reg == COUNT_FULL)
                    begin
                        // Full dictionary: start over instead of inserting.
                        res_rst_next = 1'b1;
                        count_next   = '0;
                        width_next   = BITS_RESET;
                        thresh_next  = THRESH_RESET;
                    end
                    else
                    begin
                        res_rst_next = 1'b0;
                        ram_we       = 1'b1;
                        count_next   = count_reg + COUNT_W'(1);
                        if (grow_sum > {1'b0, thresh_reg})
                        begin
                            width_next  = width_reg + BITS_W'(1);
                            thresh_next = thresh_reg << 1;
                        end
                    end
                end
                else if (rd_slot.parent == parent_reg && rd_slot.sym == sym_reg)
                begin
                    res_ins_next  = 1'b0;
                    res_rst_next  = 1'b0;
                    res_code_next = rd_slot.code;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    pos_next = csub_out;
                end
            end

            ST_RESULT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_ins_next   = res_ins_reg;
                    out_rst_next   = res_rst_reg;
                    out_code_next  = res_code_reg;
                    out_bits_next  = width_reg;
                    if (res_rst_reg)
                    begin
                        clr_addr_next = '0;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            width_reg     <= BITS_RESET;
            thresh_reg    <= THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            width_reg     <= width_next;
            thresh_reg    <= thresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        parent_reg   <= parent_next;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
        hash_reg     <= hash_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        pos_reg      <= pos_next;
        res_ins_reg  <= res_ins_next;
        res_rst_reg  <= res_rst_next;
        res_code_reg <= res_code_next;
        out_ins_reg  <= out_ins_next;
        out_rst_reg  <= out_rst_next;
        out_code_reg <= out_code_next;
        out_bits_reg <= out_bits_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_bits_reg, out_code_reg};
    assign m_axis_tuser  = {out_rst_reg, out_ins_reg};

    // The entry count never passes the dictionary size.
    `LZDH_ASSERT_ALWAYS(a_count_range, count_reg <= COUNT_FULL, "entry count beyond dictionary size")
    // An insertion only ever writes over an empty slot.
    `LZDH_ASSERT_IMPLIES(a_insert_empty, (state_reg == ST_PROBE) && ram_we, rd_slot.parent == '0, "insertion over an occupied slot")
    // A dictionary reset result is followed by a sweep from the first slot.
    `LZDH_ASSERT_NEXT(a_sweep_start, out_load && res_rst_reg, (state_reg == ST_CLEAR) && (clr_addr_reg == '0), "no table sweep after dictionary reset")
    // A dictionary reset result reports the starting code width.
    `LZDH_ASSERT_IMPLIES(a_reset_width, out_valid_reg && out_rst_reg, out_bits_reg == BITS_RESET, "dictionary reset with wrong code width")

endmodule

`default_nettype wire

// ===== hw/rtl/lzdh_ram.sv =====
// ---------------------------------------------------------------------------
// lzdh_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzdh_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 6144
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lzdh_csub.sv =====
// ---------------------------------------------------------------------------
// lzdh_csub
// Shared compare-and-subtract unit: reduces a value below twice the modulus
// into the range of the modulus.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzdh_csub #(
    parameter int WIDTH   = 13,
    parameter int MODULUS = 6144
) (
    input  logic [WIDTH:0]   din,
    output logic [WIDTH-1:0] dout
);

    localparam logic [WIDTH:0] MOD_V = (WIDTH + 1)'(MODULUS);

    logic [WIDTH:0] diff;

    // The caller keeps din below twice the modulus, so one subtraction is
    // enough and the result fits the narrower output.
    assign diff = din - MOD_V;
    assign dout = (din >= MOD_V) ? diff[WIDTH-1:0] : din[WIDTH-1:0];

endmodule

`default_nettype wire
